/* sv/imhq_pkg.sv */
`default_nettype none
package imhq_pkg;

  localparam int unsigned NODES  = 1024;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned COST_W = 32;

  // action codes
  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_LOWER  = 3'd2;
  localparam logic [2:0] ACT_RESET  = 3'd3;
  localparam logic [2:0] ACT_QUERY  = 3'd4;

  // node marks
  localparam logic [1:0] MARK_NEW    = 2'd0;
  localparam logic [1:0] MARK_QUEUED = 2'd1;
  localparam logic [1:0] MARK_DONE   = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0]         node;
    logic signed [COST_W-1:0] cost;
  } hent_t;

  typedef struct packed {
    logic [1:0]       mark;
    logic [IDX_W-1:0] slot;
  } info_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_LOOK, OP_INS, OP_REM, OP_REMLAST, OP_LOW, OP_REFUSE,
    OP_RST, OP_UP_RD, OP_UP_CMP, OP_PLACE, OP_DN_L, OP_DN_R, OP_DN_CMP, OP_CLR
  } op_e;

  typedef enum logic [3:0] {
    ST_CLR_BOOT, ST_IDLE, ST_LOOK, ST_DEC, ST_REM2, ST_UP_RD, ST_UP_CMP, ST_PLACE,
    ST_DN_L, ST_DN_R, ST_DN_CMP, ST_CLR_ACT, ST_FIN
  } state_e;

  typedef struct packed {
    op_e  op;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic       ins_ok;
    logic       rem_ok;
    logic       rem_last;
    logic       low_ok;
    logic       k_zero;
    logic       up_move;
    logic       l_in;
    logic       dn_move;
    logic       clr_last;
    logic       out_free;
  } stat_t;

endpackage
`default_nettype wire

/* sv/imhq_dp.sv */
`default_nettype none
module imhq_dp (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire imhq_pkg::cmd_t               cmd_i,
  output imhq_pkg::stat_t                   stat_o,
  input  wire [2:0]                         action_i,
  input  wire [imhq_pkg::IDX_W-1:0]         item_index_i,
  input  wire signed [imhq_pkg::COST_W-1:0] item_cost_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic                              ok_o,
  output logic [imhq_pkg::IDX_W-1:0]        out_index_o,
  output logic signed [imhq_pkg::COST_W-1:0] out_cost_o,
  output logic [1:0]                        node_mark_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);

  localparam int unsigned IW = imhq_pkg::IDX_W;
  localparam int unsigned CW = imhq_pkg::CNT_W;

  // memories
  imhq_pkg::hent_t heap_mem [imhq_pkg::NODES];
  imhq_pkg::info_t info_mem [imhq_pkg::NODES];
  logic signed [imhq_pkg::COST_W-1:0] cost_mem [imhq_pkg::NODES];

  imhq_pkg::hent_t heap_rd_q, hw_data;
  imhq_pkg::info_t info_rd_q, iw_data;
  logic signed [imhq_pkg::COST_W-1:0] cost_rd_q;
  logic [IW-1:0] hr_addr, hw_addr, iw_addr;
  logic          hw_en, iw_en, cw_en;

  // working registers
  logic [2:0]     act_q;
  logic [IW-1:0]  idx_q, k_q, clr_q;
  logic signed [imhq_pkg::COST_W-1:0] cin_q;
  logic [CW-1:0]  cnt_q;
  imhq_pkg::hent_t e_q, lc_q;
  logic           res_ok_q;
  logic [IW-1:0]  res_idx_q;
  logic signed [imhq_pkg::COST_W-1:0] res_cost_q;
  logic [1:0]     res_mark_q;

  // derived slots
  logic [IW-1:0]  p_slot;
  logic [CW-1:0]  l_slot;
  logic [CW:0]    r_slot;
  logic           r_in, left_lt, right_lt;
  logic signed [imhq_pkg::COST_W-1:0] least_cost;
  imhq_pkg::hent_t child;
  logic [IW-1:0]  child_slot;
  logic [CW-1:0]  cnt_dec;

  assign cnt_dec    = cnt_q - CW'(1);
  assign p_slot     = (k_q - IW'(1)) >> 1;
  assign l_slot     = {k_q, 1'b1};
  assign r_slot     = {1'b0, l_slot} + (CW+1)'(1);
  assign r_in       = r_slot < {1'b0, cnt_q};
  assign left_lt    = lc_q.cost < e_q.cost;
  assign least_cost = left_lt ? lc_q.cost : e_q.cost;
  assign right_lt   = r_in && (heap_rd_q.cost < least_cost);
  assign child      = right_lt ? heap_rd_q : lc_q;
  assign child_slot = right_lt ? r_slot[IW-1:0] : l_slot[IW-1:0];

  // status to the controller
  always_comb begin
    stat_o.act      = act_q;
    stat_o.ins_ok   = (cnt_q != CW'(imhq_pkg::NODES)) &&
                      (info_rd_q.mark != imhq_pkg::MARK_QUEUED);
    stat_o.rem_ok   = cnt_q != '0;
    stat_o.rem_last = cnt_q == CW'(1);
    stat_o.low_ok   = (info_rd_q.mark == imhq_pkg::MARK_QUEUED) && (cin_q <= cost_rd_q);
    stat_o.k_zero   = k_q == '0;
    stat_o.up_move  = heap_rd_q.cost > e_q.cost;
    stat_o.l_in     = l_slot < cnt_q;
    stat_o.dn_move  = left_lt || right_lt;
    stat_o.clr_last = &clr_q;
    stat_o.out_free = !out_valid_o || out_ready_i;
  end

  // memory port selection
  always_comb begin
    hr_addr = '0;
    hw_en   = 1'b0;
    hw_addr = k_q;
    hw_data = e_q;
    iw_en   = 1'b0;
    iw_addr = e_q.node;
    iw_data = '{mark: imhq_pkg::MARK_QUEUED, slot: k_q};
    cw_en   = 1'b0;
    case (cmd_i.op)
      imhq_pkg::OP_REM: begin
        hr_addr = cnt_dec[IW-1:0];
        iw_en   = 1'b1;
        iw_addr = heap_rd_q.node;
        iw_data = '{mark: imhq_pkg::MARK_DONE, slot: '0};
      end
      imhq_pkg::OP_INS, imhq_pkg::OP_LOW: cw_en = 1'b1;
      imhq_pkg::OP_UP_RD: hr_addr = p_slot;
      imhq_pkg::OP_UP_CMP: begin
        if (stat_o.up_move) begin
          hw_en   = 1'b1;
          hw_data = heap_rd_q;
          iw_en   = 1'b1;
          iw_addr = heap_rd_q.node;
        end
      end
      imhq_pkg::OP_PLACE: begin
        hw_en = 1'b1;
        iw_en = 1'b1;
      end
      imhq_pkg::OP_DN_L: hr_addr = l_slot[IW-1:0];
      imhq_pkg::OP_DN_R: hr_addr = r_slot[IW-1:0];
      imhq_pkg::OP_DN_CMP: begin
        if (stat_o.dn_move) begin
          hw_en   = 1'b1;
          hw_data = child;
          iw_en   = 1'b1;
          iw_addr = child.node;
        end
      end
      imhq_pkg::OP_CLR: begin
        iw_en   = 1'b1;
        iw_addr = clr_q;
        iw_data = '{mark: imhq_pkg::MARK_NEW, slot: '0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hw_en) heap_mem[hw_addr] <= hw_data;
    heap_rd_q <= heap_mem[hr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (iw_en) info_mem[iw_addr] <= iw_data;
    info_rd_q <= info_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cw_en) cost_mem[idx_q] <= cin_q;
    cost_rd_q <= cost_mem[idx_q];
  end

  // control counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= cmd_i.fin || (out_valid_o && !out_ready_i);
      case (cmd_i.op)
        imhq_pkg::OP_INS: cnt_q <= cnt_q + CW'(1);
        imhq_pkg::OP_REM: cnt_q <= cnt_dec;
        imhq_pkg::OP_RST: begin
          cnt_q <= '0;
          clr_q <= '0;
        end
        imhq_pkg::OP_CLR: clr_q <= clr_q + IW'(1);
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      imhq_pkg::OP_LOAD: begin
        act_q <= action_i;
        idx_q <= item_index_i;
        cin_q <= item_cost_i;
      end
      imhq_pkg::OP_INS: begin
        e_q        <= '{node: idx_q, cost: cin_q};
        k_q        <= cnt_q[IW-1:0];
        res_ok_q   <= 1'b1;
        res_idx_q  <= idx_q;
        res_cost_q <= cin_q;
        res_mark_q <= info_rd_q.mark;
      end
      imhq_pkg::OP_LOW: begin
        e_q        <= '{node: idx_q, cost: cin_q};
        k_q        <= info_rd_q.slot;
        res_ok_q   <= 1'b1;
        res_idx_q  <= idx_q;
        res_cost_q <= cin_q;
        res_mark_q <= info_rd_q.mark;
      end
      imhq_pkg::OP_REM: begin
        res_ok_q   <= 1'b1;
        res_idx_q  <= heap_rd_q.node;
        res_cost_q <= heap_rd_q.cost;
        res_mark_q <= imhq_pkg::MARK_QUEUED;
      end
      imhq_pkg::OP_REMLAST: begin
        e_q <= heap_rd_q;
        k_q <= '0;
      end
      imhq_pkg::OP_REFUSE, imhq_pkg::OP_RST: begin
        res_ok_q   <= (act_q == imhq_pkg::ACT_QUERY) || (act_q == imhq_pkg::ACT_RESET);
        res_idx_q  <= idx_q;
        res_cost_q <= cost_rd_q;
        res_mark_q <= info_rd_q.mark;
      end
      imhq_pkg::OP_UP_CMP: if (stat_o.up_move) k_q <= p_slot;
      imhq_pkg::OP_DN_R:   lc_q <= heap_rd_q;
      imhq_pkg::OP_DN_CMP: if (stat_o.dn_move) k_q <= child_slot;
      default: ;
    endcase
    if (cmd_i.fin) begin
      ok_o        <= res_ok_q;
      out_index_o <= res_idx_q;
      out_cost_o  <= res_cost_q;
      node_mark_o <= res_mark_q;
      is_empty_o  <= cnt_q == '0;
      is_full_o   <= cnt_q == CW'(imhq_pkg::NODES);
    end
  end

endmodule
`default_nettype wire

/* sv/imhq_ctrl.sv */
`default_nettype none
module imhq_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire imhq_pkg::stat_t stat_i,
  output imhq_pkg::cmd_t       cmd_o
);

  imhq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= imhq_pkg::ST_CLR_BOOT;
    else         state_q <= state_d;
  end

  // sequencing
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = imhq_pkg::OP_NONE;
    cmd_o.fin  = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      imhq_pkg::ST_CLR_BOOT: begin
        cmd_o.op = imhq_pkg::OP_CLR;
        if (stat_i.clr_last) state_d = imhq_pkg::ST_IDLE;
      end
      imhq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = imhq_pkg::OP_LOAD;
          state_d  = imhq_pkg::ST_LOOK;
        end
      end
      imhq_pkg::ST_LOOK: begin
        cmd_o.op = imhq_pkg::OP_LOOK;
        state_d  = imhq_pkg::ST_DEC;
      end
      imhq_pkg::ST_DEC: begin
        cmd_o.op = imhq_pkg::OP_REFUSE;
        state_d  = imhq_pkg::ST_FIN;
        if (stat_i.act == imhq_pkg::ACT_INSERT && stat_i.ins_ok) begin
          cmd_o.op = imhq_pkg::OP_INS;
          state_d  = imhq_pkg::ST_UP_RD;
        end else if (stat_i.act == imhq_pkg::ACT_REMOVE && stat_i.rem_ok) begin
          cmd_o.op = imhq_pkg::OP_REM;
          state_d  = stat_i.rem_last ? imhq_pkg::ST_FIN : imhq_pkg::ST_REM2;
        end else if (stat_i.act == imhq_pkg::ACT_LOWER && stat_i.low_ok) begin
          cmd_o.op = imhq_pkg::OP_LOW;
          state_d  = imhq_pkg::ST_UP_RD;
        end else if (stat_i.act == imhq_pkg::ACT_RESET) begin
          cmd_o.op = imhq_pkg::OP_RST;
          state_d  = imhq_pkg::ST_CLR_ACT;
        end
      end
      imhq_pkg::ST_REM2: begin
        cmd_o.op = imhq_pkg::OP_REMLAST;
        state_d  = imhq_pkg::ST_DN_L;
      end
      imhq_pkg::ST_UP_RD: begin
        if (stat_i.k_zero) begin
          state_d = imhq_pkg::ST_PLACE;
        end else begin
          cmd_o.op = imhq_pkg::OP_UP_RD;
          state_d  = imhq_pkg::ST_UP_CMP;
        end
      end
      imhq_pkg::ST_UP_CMP: begin
        cmd_o.op = imhq_pkg::OP_UP_CMP;
        state_d  = stat_i.up_move ? imhq_pkg::ST_UP_RD : imhq_pkg::ST_PLACE;
      end
      imhq_pkg::ST_PLACE: begin
        cmd_o.op = imhq_pkg::OP_PLACE;
        state_d  = imhq_pkg::ST_FIN;
      end
      imhq_pkg::ST_DN_L: begin
        if (stat_i.l_in) begin
          cmd_o.op = imhq_pkg::OP_DN_L;
          state_d  = imhq_pkg::ST_DN_R;
        end else begin
          state_d = imhq_pkg::ST_PLACE;
        end
      end
      imhq_pkg::ST_DN_R: begin
        cmd_o.op = imhq_pkg::OP_DN_R;
        state_d  = imhq_pkg::ST_DN_CMP;
      end
      imhq_pkg::ST_DN_CMP: begin
        cmd_o.op = imhq_pkg::OP_DN_CMP;
        state_d  = stat_i.dn_move ? imhq_pkg::ST_DN_L : imhq_pkg::ST_PLACE;
      end
      imhq_pkg::ST_CLR_ACT: begin
        cmd_o.op = imhq_pkg::OP_CLR;
        if (stat_i.clr_last) state_d = imhq_pkg::ST_FIN;
      end
      imhq_pkg::ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = imhq_pkg::ST_IDLE;
        end
      end
      default: state_d = imhq_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* sv/indexed_min_heap_queue_unit.sv */
`default_nettype none
// Channel  Handshake              Payload
// in       in_valid_i/in_ready_o  action_i, item_index_i, item_cost_i
// out      out_valid_o/out_ready_i ok_o, out_index_o, out_cost_o, node_mark_o,
//                                 is_empty_o, is_full_o
// A request is loaded, looked up and decided, then sifted: each level going
// up reads the parent, then compares and moves; each level going down reads
// both children one after the other, then compares and moves, the reads
// sharing the single read port of the heap memory. Reset action: clears all 1024 node entries.
// After reset all 1024 entries of the node table are cleared before in_ready_o.
// One result register: the next request is taken while a result waits.
module indexed_min_heap_queue_unit (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire [2:0]                         action_i,
  input  wire [imhq_pkg::IDX_W-1:0]         item_index_i,
  input  wire signed [imhq_pkg::COST_W-1:0] item_cost_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic                              ok_o,
  output logic [imhq_pkg::IDX_W-1:0]        out_index_o,
  output logic signed [imhq_pkg::COST_W-1:0] out_cost_o,
  output logic [1:0]                        node_mark_o,
  output logic                              is_empty_o,
  output logic                              is_full_o
);

  imhq_pkg::cmd_t  cmd;
  imhq_pkg::stat_t stat;

  imhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  imhq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .action_i     (action_i),
    .item_index_i (item_index_i),
    .item_cost_i  (item_cost_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ok_o         (ok_o),
    .out_index_o  (out_index_o),
    .out_cost_o   (out_cost_o),
    .node_mark_o  (node_mark_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

endmodule
`default_nettype wire
